// File: sv/blkpad_pkg.sv
// Shared types and constants for the block cipher pad/unpad block.
package blkpad_pkg;

   // Transaction payloads
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_present;
      logic       out_end;
   } rsp_type;

   // Sequencer <-> pad checker
   typedef struct packed {
      logic       start;
      logic [2:0] scheme;
      logic       seen;
      logic       prev_zero;
      logic       prev_space;
   } chk_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } chk_stat_type;

   // Padding schemes
   localparam logic [2:0] SCHEME_NONE     = 3'd0;
   localparam logic [2:0] SCHEME_X923     = 3'd1;
   localparam logic [2:0] SCHEME_PKCS7    = 3'd2;
   localparam logic [2:0] SCHEME_ISO10126 = 3'd3;
   localparam logic [2:0] SCHEME_ISO7816  = 3'd4;
   localparam logic [2:0] SCHEME_ZERO     = 3'd5;
   localparam logic [2:0] SCHEME_SPACE    = 3'd6;

   // CSR map
   localparam int         CSR_IDX_W     = 3;
   localparam int         CSR_DATA_W    = 16;
   localparam logic [2:0] CSR_DIRECTION = 3'd0;
   localparam logic [2:0] CSR_SCHEME    = 3'd1;
   localparam logic [2:0] CSR_BLOCK     = 3'd2;
   localparam logic [2:0] CSR_MODE      = 3'd3;
   localparam logic [2:0] CSR_SEED      = 3'd4;

   localparam int         BLOCK_W     = 6;
   localparam logic [5:0] BLOCK_RESET = 6'd32;

   // Pad bytes
   localparam logic [7:0] PAD_ZERO     = 8'h00;
   localparam logic [7:0] PAD_SPACE    = 8'h20;
   localparam logic [7:0] PAD_ISO_MARK = 8'h80;

   // Noise generator
   localparam int          LFSR_W     = 16;
   localparam logic [15:0] LFSR_MASK  = 16'hB400;
   localparam logic [15:0] SEED_RESET = 16'd44257;

endpackage

// File: sv/blkpad_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module blkpad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/blkpad_noise.sv
// Galois LFSR that yields one random pad byte per advance.
module blkpad_noise (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [blkpad_pkg::LFSR_W-1:0]   seed,
   input  logic                            advance,
   output logic [7:0]                      noise_byte
);

   logic [blkpad_pkg::LFSR_W-1:0] lfsr_ff;
   logic [blkpad_pkg::LFSR_W-1:0] lfsr_in;
   logic [blkpad_pkg::LFSR_W-1:0] step8;

   // eight right shifts, mask applied when a one falls out
   always_comb begin
      step8 = lfsr_ff;
      for (int k = 0; k < 8; k++) begin
         if (step8[0]) begin
            step8 = (step8 >> 1) ^ blkpad_pkg::LFSR_MASK;
         end else begin
            step8 = step8 >> 1;
         end
      end
   end

   always_comb begin
      lfsr_in = lfsr_ff;
      if (load) begin
         lfsr_in = seed;
      end else if (advance) begin
         lfsr_in = step8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= blkpad_pkg::SEED_RESET;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end

   assign noise_byte = step8[7:0];

endmodule

// File: sv/blkpad_check.sv
// Pad checker: scans the last block backward, addressing each stored byte, then checking its data.
module blkpad_check #(
   parameter int MAX_BLOCK_BYTES = 32,
   localparam int CNT_W = $clog2(MAX_BLOCK_BYTES + 1),
   localparam int IDX_W = $clog2(MAX_BLOCK_BYTES)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  blkpad_pkg::chk_cmd_type   cmd,
   input  logic [CNT_W-1:0]          block_size,
   output logic [IDX_W-1:0]          rd_addr,
   input  logic [7:0]                rd_data,
   output blkpad_pkg::chk_stat_type  stat,
   output logic [CNT_W-1:0]          pad_len
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             phase_ff, phase_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [7:0]       last_ff, last_in;
   logic [CNT_W-1:0] len_ff, len_in;

   logic [CNT_W-1:0] j_p1;
   logic [CNT_W-1:0] pos;
   logic             stop;
   logic [CNT_W-1:0] len_v;
   logic [7:0]       run_byte;
   logic             prev_same;

   assign j_p1    = j_ff + CNT_W'(1);
   assign pos     = block_size - j_ff - CNT_W'(1);
   assign rd_addr = pos[IDX_W-1:0];

   assign run_byte  = (cmd.scheme == blkpad_pkg::SCHEME_ZERO) ?
                      blkpad_pkg::PAD_ZERO : blkpad_pkg::PAD_SPACE;
   assign prev_same = (cmd.scheme == blkpad_pkg::SCHEME_ZERO) ?
                      cmd.prev_zero : cmd.prev_space;

   // rd_data is the byte at distance j_ff from the block end
   always_comb begin
      stop  = 1'b0;
      len_v = '0;
      case (cmd.scheme)
         blkpad_pkg::SCHEME_X923,
         blkpad_pkg::SCHEME_PKCS7,
         blkpad_pkg::SCHEME_ISO10126: begin
            if (j_ff == '0) begin
               if (rd_data == 8'd0 || 9'(rd_data) > 9'(block_size)) begin
                  stop = 1'b1;
               end else if (cmd.scheme == blkpad_pkg::SCHEME_ISO10126 ||
                            rd_data == 8'd1) begin
                  stop  = 1'b1;
                  len_v = CNT_W'(rd_data);
               end
            end else begin
               if ((cmd.scheme == blkpad_pkg::SCHEME_X923) ?
                   (rd_data != blkpad_pkg::PAD_ZERO) : (rd_data != last_ff)) begin
                  stop = 1'b1;
               end else if (9'(j_p1) == 9'(last_ff)) begin
                  stop  = 1'b1;
                  len_v = CNT_W'(last_ff);
               end
            end
         end
         blkpad_pkg::SCHEME_ISO7816: begin
            if (rd_data == blkpad_pkg::PAD_ZERO) begin
               // an all-zero block carries no marker
               stop = (j_p1 == block_size);
            end else begin
               stop = 1'b1;
               if (rd_data == blkpad_pkg::PAD_ISO_MARK) begin
                  len_v = j_p1;
               end
            end
         end
         blkpad_pkg::SCHEME_ZERO,
         blkpad_pkg::SCHEME_SPACE: begin
            if (rd_data == run_byte) begin
               if (j_p1 == block_size) begin
                  stop = 1'b1;
                  // whole block of pad after a block ending the same way: keep it
                  if (!(cmd.seen && prev_same)) begin
                     len_v = block_size;
                  end
               end
            end else begin
               stop  = 1'b1;
               len_v = j_ff;
            end
         end
         default: begin
            stop = 1'b1;
         end
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      j_in     = j_ff;
      last_in  = last_ff;
      len_in   = len_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         j_in     = '0;
         phase_in = 1'b0;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            phase_in = 1'b1;
         end else if (stop) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            len_in  = len_v;
         end else begin
            if (j_ff == '0) begin
               last_in = rd_data;
            end
            j_in     = j_p1;
            phase_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      j_ff    <= j_in;
      last_ff <= last_in;
      len_ff  <= len_in;
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign pad_len   = len_ff;

endmodule

// File: sv/block_cipher_pad_unpad.sv
// Top level: block cipher message padding and unpadding sequencer.
//
// Usage
//   req_*  : message bytes in; byte_present=0 with message_end=1 is a bare end.
//   rsp_*  : result transactions; out_end marks the last one of a message.
//   csr_*  : register writes (direction, scheme, block_bytes, mode_pads,
//            random_seed); write only while no transaction is in flight.
// Timing
//   One request at a time: req_ready is high only between transactions.
//   Pass-through byte: each request is accepted, stepped, then flushed.
//   Pad end: the pad bytes follow one by one, each waiting for a free output.
//   Unpad: each held byte leaves through the single RAM read port, first
//   addressed, then taken from the registered read data. A full block leaves
//   when the next byte arrives; at the end the pad check runs before kept bytes.
//   The last emitted byte is held back one slot so out_end can be attached.
// Reset
//   Synchronous. Registers return to defaults (pad direction, scheme none,
//   32-byte block, padding mode on), message state clears, LFSR = 0xACE1.
// Backpressure
//   Output register plus the held-back byte; the sequencer freezes when both
//   are full, and no new request is taken until the current one drains.
module block_cipher_pad_unpad #(
   parameter int MAX_BLOCK_BYTES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  blkpad_pkg::req_type                 req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output blkpad_pkg::rsp_type                 rsp_data,
   input  logic                                csr_write_en,
   input  logic [blkpad_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [blkpad_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CNT_W = $clog2(MAX_BLOCK_BYTES + 1);
   localparam int IDX_W = $clog2(MAX_BLOCK_BYTES);
   localparam int EXT_W = (CNT_W > blkpad_pkg::BLOCK_W) ? CNT_W : blkpad_pkg::BLOCK_W;

   typedef enum logic [3:0] {
      S_IDLE,   // waiting for a request
      S_STEP,   // dispatch on direction
      S_PAD,    // generate pad bytes
      S_REL,    // release a full held block
      S_WR,     // store the new byte
      S_END,    // unpad end: decide on a pad check
      S_CHK,    // pad checker running
      S_OUT,    // flush kept bytes
      S_FIN     // push the held-back byte / end marker
   } state_type;

   // Configuration
   logic                            direction_ff, direction_in;
   logic [2:0]                      scheme_ff, scheme_in;
   logic [blkpad_pkg::BLOCK_W-1:0]  block_bytes_ff, block_bytes_in;
   logic                            mode_pads_ff, mode_pads_in;

   // Sequencer and message state
   state_type            state_ff, state_in;
   blkpad_pkg::req_type  req_ff, req_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic                 seen_ff, seen_in;
   logic                 lz_ff, lz_in;
   logic                 ls_ff, ls_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 rd_ok_ff, rd_ok_in;

   // Held-back byte and output register
   logic                 pend_vld_ff, pend_vld_in;
   logic [7:0]           pend_byte_ff, pend_byte_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   blkpad_pkg::rsp_type  rsp_ff, rsp_in;

   // Datapath
   logic [EXT_W-1:0]     blk_ext;
   logic [CNT_W-1:0]     eff_b;
   logic                 active;
   logic [CNT_W-1:0]     fill_p1;
   logic [CNT_W-1:0]     fill_next;
   logic                 out_free;
   logic                 can_emit;
   logic                 emit;
   logic [7:0]           emit_byte;
   logic                 pad_last;
   logic [7:0]           pad_val;
   logic                 noise_adv;
   logic [7:0]           noise_byte;
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_raddr;
   logic [7:0]           ram_rdata;
   logic                 chk_start;
   logic [IDX_W-1:0]     chk_raddr;
   logic [CNT_W-1:0]     chk_len;
   blkpad_pkg::chk_cmd_type  chk_cmd;
   blkpad_pkg::chk_stat_type chk_stat;

   // Effective block size: 0 acts as 1, oversize clamps to the RAM depth
   assign blk_ext = EXT_W'(block_bytes_ff);
   assign eff_b   = (blk_ext == '0) ? CNT_W'(1) :
                    (blk_ext > EXT_W'(MAX_BLOCK_BYTES)) ? CNT_W'(MAX_BLOCK_BYTES) :
                    CNT_W'(blk_ext);

   assign active = mode_pads_ff && (scheme_ff != blkpad_pkg::SCHEME_NONE) &&
                   (scheme_ff <= blkpad_pkg::SCHEME_SPACE);

   // pad direction: fill is message length mod B
   assign fill_p1   = fill_ff + CNT_W'(1);
   assign fill_next = (fill_p1 == eff_b) ? '0 : fill_p1;

   assign out_free = !rsp_vld_ff || rsp_ready;
   assign can_emit = !pend_vld_ff || out_free;

   // Pad byte generator; cnt_ff holds the pad length
   assign pad_last = ((idx_ff + CNT_W'(1)) == cnt_ff);

   always_comb begin
      case (scheme_ff)
         blkpad_pkg::SCHEME_X923:     pad_val = pad_last ? 8'(cnt_ff) : blkpad_pkg::PAD_ZERO;
         blkpad_pkg::SCHEME_PKCS7:    pad_val = 8'(cnt_ff);
         blkpad_pkg::SCHEME_ISO10126: pad_val = pad_last ? 8'(cnt_ff) : noise_byte;
         blkpad_pkg::SCHEME_ISO7816:  pad_val = (idx_ff == '0) ? blkpad_pkg::PAD_ISO_MARK :
                                                                 blkpad_pkg::PAD_ZERO;
         blkpad_pkg::SCHEME_ZERO:     pad_val = blkpad_pkg::PAD_ZERO;
         default:                     pad_val = blkpad_pkg::PAD_SPACE;
      endcase
   end

   // Sequencer
   always_comb begin
      direction_in   = direction_ff;
      scheme_in      = scheme_ff;
      block_bytes_in = block_bytes_ff;
      mode_pads_in   = mode_pads_ff;
      state_in       = state_ff;
      req_in         = req_ff;
      fill_in        = fill_ff;
      seen_in        = seen_ff;
      lz_in          = lz_ff;
      ls_in          = ls_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      rd_ok_in       = 1'b1;
      pend_vld_in    = pend_vld_ff;
      pend_byte_in   = pend_byte_ff;
      rsp_vld_in     = rsp_vld_ff && !rsp_ready;
      rsp_in         = rsp_ff;
      emit           = 1'b0;
      emit_byte      = pend_byte_ff;
      noise_adv      = 1'b0;
      ram_we         = 1'b0;
      chk_start      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (!direction_ff) begin
               if (req_ff.byte_present) begin
                  if (can_emit) begin
                     emit      = 1'b1;
                     emit_byte = req_ff.data_byte;
                     fill_in   = fill_next;
                     if (req_ff.message_end && active) begin
                        cnt_in   = eff_b - fill_next;
                        idx_in   = '0;
                        state_in = S_PAD;
                     end else begin
                        state_in = S_FIN;
                     end
                  end
               end else if (req_ff.message_end && active) begin
                  cnt_in   = eff_b - fill_ff;
                  idx_in   = '0;
                  state_in = S_PAD;
               end else begin
                  state_in = S_FIN;
               end
            end else begin
               if (req_ff.byte_present && fill_ff >= eff_b) begin
                  idx_in   = '0;
                  rd_ok_in = 1'b0;
                  state_in = S_REL;
               end else if (req_ff.byte_present) begin
                  state_in = S_WR;
               end else if (req_ff.message_end) begin
                  state_in = S_END;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_PAD: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_byte = pad_val;
               noise_adv = (scheme_ff == blkpad_pkg::SCHEME_ISO10126) && !pad_last;
               idx_in    = idx_ff + CNT_W'(1);
               if (pad_last) begin
                  state_in = S_FIN;
               end
            end
         end
         S_REL: begin
            if (rd_ok_ff && can_emit) begin
               emit      = 1'b1;
               emit_byte = ram_rdata;
               rd_ok_in  = 1'b0;
               if (idx_ff == eff_b - CNT_W'(1)) begin
                  // remember how the released block ended
                  seen_in  = 1'b1;
                  lz_in    = (ram_rdata == blkpad_pkg::PAD_ZERO);
                  ls_in    = (ram_rdata == blkpad_pkg::PAD_SPACE);
                  fill_in  = '0;
                  state_in = S_WR;
               end else begin
                  idx_in = idx_ff + CNT_W'(1);
               end
            end
         end
         S_WR: begin
            ram_we   = 1'b1;
            fill_in  = fill_p1;
            state_in = req_ff.message_end ? S_END : S_FIN;
         end
         S_END: begin
            if (active && fill_ff == eff_b) begin
               chk_start = 1'b1;
               state_in  = S_CHK;
            end else if (fill_ff == '0) begin
               state_in = S_FIN;
            end else begin
               cnt_in   = fill_ff;
               idx_in   = '0;
               rd_ok_in = 1'b0;
               state_in = S_OUT;
            end
         end
         S_CHK: begin
            if (chk_stat.done) begin
               cnt_in   = eff_b - chk_len;
               idx_in   = '0;
               rd_ok_in = 1'b0;
               state_in = (chk_len == eff_b) ? S_FIN : S_OUT;
            end
         end
         S_OUT: begin
            if (rd_ok_ff && can_emit) begin
               emit      = 1'b1;
               emit_byte = ram_rdata;
               rd_ok_in  = 1'b0;
               idx_in    = idx_ff + CNT_W'(1);
               if ((idx_ff + CNT_W'(1)) == cnt_ff) begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            if (pend_vld_ff) begin
               if (out_free) begin
                  rsp_in.out_byte    = pend_byte_ff;
                  rsp_in.out_present = 1'b1;
                  rsp_in.out_end     = req_ff.message_end;
                  rsp_vld_in         = 1'b1;
                  pend_vld_in        = 1'b0;
                  state_in           = S_IDLE;
                  if (req_ff.message_end) begin
                     fill_in = '0;
                     seen_in = 1'b0;
                     lz_in   = 1'b0;
                     ls_in   = 1'b0;
                  end
               end
            end else if (req_ff.message_end) begin
               // end with nothing emitted: bare marker
               if (out_free) begin
                  rsp_in.out_byte    = 8'h00;
                  rsp_in.out_present = 1'b0;
                  rsp_in.out_end     = 1'b1;
                  rsp_vld_in         = 1'b1;
                  fill_in            = '0;
                  seen_in            = 1'b0;
                  lz_in              = 1'b0;
                  ls_in              = 1'b0;
                  state_in           = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // new byte goes to the held-back slot, the previous one moves out
      if (emit) begin
         if (pend_vld_ff) begin
            rsp_in.out_byte    = pend_byte_ff;
            rsp_in.out_present = 1'b1;
            rsp_in.out_end     = 1'b0;
            rsp_vld_in         = 1'b1;
         end
         pend_vld_in  = 1'b1;
         pend_byte_in = emit_byte;
      end

      // CSR writes; direction and block size restart the message
      if (csr_write_en) begin
         case (csr_index)
            blkpad_pkg::CSR_DIRECTION: begin
               direction_in = csr_wdata[0];
               fill_in      = '0;
               seen_in      = 1'b0;
               lz_in        = 1'b0;
               ls_in        = 1'b0;
            end
            blkpad_pkg::CSR_SCHEME: begin
               scheme_in = csr_wdata[2:0];
            end
            blkpad_pkg::CSR_BLOCK: begin
               block_bytes_in = csr_wdata[blkpad_pkg::BLOCK_W-1:0];
               fill_in        = '0;
               seen_in        = 1'b0;
               lz_in          = 1'b0;
               ls_in          = 1'b0;
            end
            blkpad_pkg::CSR_MODE: begin
               mode_pads_in = csr_wdata[0];
            end
            default: begin
               // seed is loaded inside the noise generator
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      pend_byte_ff <= pend_byte_in;
      rsp_ff       <= rsp_in;
      if (reset) begin
         direction_ff   <= 1'b0;
         scheme_ff      <= blkpad_pkg::SCHEME_NONE;
         block_bytes_ff <= blkpad_pkg::BLOCK_RESET;
         mode_pads_ff   <= 1'b1;
         state_ff       <= S_IDLE;
         fill_ff        <= '0;
         seen_ff        <= 1'b0;
         lz_ff          <= 1'b0;
         ls_ff          <= 1'b0;
         rd_ok_ff       <= 1'b0;
         pend_vld_ff    <= 1'b0;
         rsp_vld_ff     <= 1'b0;
      end else begin
         direction_ff   <= direction_in;
         scheme_ff      <= scheme_in;
         block_bytes_ff <= block_bytes_in;
         mode_pads_ff   <= mode_pads_in;
         state_ff       <= state_in;
         fill_ff        <= fill_in;
         seen_ff        <= seen_in;
         lz_ff          <= lz_in;
         ls_ff          <= ls_in;
         rd_ok_ff       <= rd_ok_in;
         pend_vld_ff    <= pend_vld_in;
         rsp_vld_ff     <= rsp_vld_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // Block store: checker owns the read port while it runs
   assign ram_raddr = (state_ff == S_CHK) ? chk_raddr : idx_ff[IDX_W-1:0];

   blkpad_ram #(
      .WIDTH (8),
      .DEPTH (MAX_BLOCK_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff[IDX_W-1:0]),
      .wr_data (req_ff.data_byte),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign chk_cmd.start      = chk_start;
   assign chk_cmd.scheme     = scheme_ff;
   assign chk_cmd.seen       = seen_ff;
   assign chk_cmd.prev_zero  = lz_ff;
   assign chk_cmd.prev_space = ls_ff;

   blkpad_check #(
      .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
   ) u_check (
      .clock      (clock),
      .reset      (reset),
      .cmd        (chk_cmd),
      .block_size (eff_b),
      .rd_addr    (chk_raddr),
      .rd_data    (ram_rdata),
      .stat       (chk_stat),
      .pad_len    (chk_len)
   );

   blkpad_noise u_noise (
      .clock      (clock),
      .reset      (reset),
      .load       (csr_write_en && (csr_index == blkpad_pkg::CSR_SEED)),
      .seed       (csr_wdata),
      .advance    (noise_adv),
      .noise_byte (noise_byte)
   );

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= eff_b)
      else $error("fill count beyond block size");

   a_chk_alive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK) |-> (chk_stat.busy || chk_stat.done))
      else $error("sequencer waits on an idle pad checker");

   a_done_in_chk: assert property (@(posedge clock) disable iff (reset)
      chk_stat.done |-> (state_ff == S_CHK))
      else $error("pad check result outside check state");

   a_accept_clean: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (!pend_vld_ff && !chk_stat.busy))
      else $error("transaction accepted with work still pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PAD || state_ff == S_OUT) |-> (idx_ff < cnt_ff))
      else $error("emit index past its count");
`endif

endmodule

// File: tb/sv/tb_block_cipher_pad_unpad.sv
// Self-checking testbench for block_cipher_pad_unpad: directed and random pad/unpad traffic.
module tb_block_cipher_pad_unpad;
   timeunit 1ns;
   timeprecision 1ps;

   import blkpad_pkg::*;

   // Run shape
   localparam int          STORE_DEPTH    = 32;      // MAX_BLOCK_BYTES of the instance
   localparam int          RESET_CYCLES   = 12;
   localparam int          RANDOM_ITEMS   = 220;
   // Quiet time before a register write / the final verdict. A held unpad byte
   // or an ignored bare item gives no response, so queue-empty alone is not idle.
   localparam int          SETTLE_CYCLES  = 100;
   localparam int          DRAIN_LIMIT    = 100000;
   // Worst case per transaction: 33 responses, each behind the longest response
   // stall, plus a full-block release and pad check at B=32. ~300 transactions
   // plus ~200 register writes stay well under 2 ms; 20 ms leaves ample margin.
   localparam int          TIMEOUT_NS     = 20_000_000;
   localparam logic [2:0]  SCHEME_UNKNOWN = 3'd7;    // undefined code, acts as none

   logic                       clock        = 1'b0;
   logic                       reset        = 1'b1;
   logic                       req_valid    = 1'b0;
   logic                       req_ready;
   req_type                    req_data     = '0;
   logic                       rsp_valid;
   logic                       rsp_ready    = 1'b1;
   rsp_type                    rsp_data;
   logic                       csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index    = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata    = '0;

   // Both sides run back to back while set
   logic                       calm_mode    = 1'b0;
   int unsigned                ready_hold   = 0;
   int unsigned                error_count  = 0;
   int unsigned                sent_items   = 0;

   // Mirror of the block's registers and message state
   logic                       cur_unpad;
   logic [2:0]                 cur_scheme;
   logic [5:0]                 cur_block;
   logic                       cur_mode_pads;
   logic [15:0]                noise_reg;
   logic [7:0]                 held_bytes [STORE_DEPTH];
   int unsigned                held_fill;
   logic                       prior_block_seen;
   logic                       prior_ended_zero;
   logic                       prior_ended_space;

   // Output bytes still owed by the block, oldest first
   rsp_type                    out_stream_q [$];

   always #2 clock = ~clock;

   block_cipher_pad_unpad i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Error reporting
   // ---------------------------------------------------------------------
   task automatic report_error(string msg);
      error_count++;
      // Cap the log; the count keeps going
      if (error_count <= 40) $display("%0t: %s", $time, msg);
   endtask

   // Half the time back to back, often a short pause, now and then a long gap
   function automatic int unsigned random_pause();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm_mode || roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   // block_bytes 0 acts as 1, anything above the store depth as the depth
   function automatic int unsigned active_block_bytes();
      if (cur_block == 0) return 1;
      if (cur_block > STORE_DEPTH) return STORE_DEPTH;
      return cur_block;
   endfunction

   function automatic void clear_message_state();
      held_fill         = 0;
      prior_block_seen  = 1'b0;
      prior_ended_zero  = 1'b0;
      prior_ended_space = 1'b0;
   endfunction

   // Galois LFSR, right shift, eight shifts per random pad byte
   function automatic logic [7:0] next_noise();
      int unsigned k;
      logic        lsb;
      for (k = 0; k < 8; k++) begin
         lsb       = noise_reg[0];
         noise_reg = noise_reg >> 1;
         if (lsb) noise_reg = noise_reg ^ LFSR_MASK;
      end
      return noise_reg[7:0];
   endfunction

   // Pad byte idx of a pad of plen bytes; filler stands in for random bytes.
   // Shared by the predictor (LFSR filler) and the unpad stimulus (random filler).
   function automatic logic [7:0] pad_byte(logic [2:0] scheme_sel, int unsigned idx,
                                           int unsigned plen, logic [7:0] filler);
      logic [7:0] len_byte;
      logic       tail;
      len_byte = plen;
      tail     = (idx + 1 == plen);
      case (scheme_sel)
         SCHEME_X923:     return tail ? len_byte : PAD_ZERO;
         SCHEME_PKCS7:    return len_byte;
         SCHEME_ISO10126: return tail ? len_byte : filler;
         SCHEME_ISO7816:  return (idx == 0) ? PAD_ISO_MARK : PAD_ZERO;
         SCHEME_ZERO:     return PAD_ZERO;
         SCHEME_SPACE:    return PAD_SPACE;
         default:         return filler;
      endcase
   endfunction

   // Pad length recognized in a full last block, 0 when the pad is bad
   function automatic int unsigned strip_length(int unsigned b);
      int unsigned last_val, run, i;
      logic [7:0]  fill_byte;
      logic        prior_match;
      last_val = held_bytes[b-1];
      case (cur_scheme)
         SCHEME_X923: begin
            if (last_val == 0 || last_val > b) return 0;
            for (i = b - last_val; i + 1 < b; i++)
               if (held_bytes[i] != PAD_ZERO) return 0;
            return last_val;
         end
         SCHEME_PKCS7: begin
            if (last_val == 0 || last_val > b) return 0;
            for (i = b - last_val; i < b; i++)
               if (held_bytes[i] != last_val) return 0;
            return last_val;
         end
         SCHEME_ISO10126: begin
            return (last_val == 0 || last_val > b) ? 0 : last_val;
         end
         SCHEME_ISO7816: begin
            run = 0;
            while (run < b && held_bytes[b-1-run] == PAD_ZERO) run++;
            if (run == b) return 0;
            return (held_bytes[b-1-run] == PAD_ISO_MARK) ? run + 1 : 0;
         end
         SCHEME_ZERO, SCHEME_SPACE: begin
            fill_byte   = (cur_scheme == SCHEME_ZERO) ? PAD_ZERO : PAD_SPACE;
            prior_match = (cur_scheme == SCHEME_ZERO) ? prior_ended_zero : prior_ended_space;
            run = 0;
            while (run < b && held_bytes[b-1-run] == fill_byte) run++;
            // an all-pad last block is real data if an earlier block ended the same way
            if (run == b && prior_block_seen && prior_match) return 0;
            return run;
         end
         default: return 0;
      endcase
   endfunction

   function automatic rsp_type make_out(logic [7:0] value, logic present);
      rsp_type r;
      r.out_byte    = present ? value : 8'h00;
      r.out_present = present;
      r.out_end     = 1'b0;
      return r;
   endfunction

   // Advance the mirror by one accepted request and queue the bytes it releases
   task automatic pad_unpad_step(req_type item);
      rsp_type     step_q [$];
      rsp_type     last_out;
      int unsigned b, plen, keep, i;
      logic        active;
      logic [7:0]  filler;
      b      = active_block_bytes();
      active = cur_mode_pads && cur_scheme != SCHEME_NONE && cur_scheme <= SCHEME_SPACE;
      if (!cur_unpad) begin
         // pad: bytes pass through, pad block follows the end
         if (item.byte_present) begin
            step_q.push_back(make_out(item.data_byte, 1'b1));
            held_fill = (held_fill + 1) % b;
         end
         if (item.message_end && active) begin
            plen = b - held_fill;
            for (i = 0; i < plen; i++) begin
               filler = PAD_ZERO;
               if (cur_scheme == SCHEME_ISO10126 && i + 1 != plen) filler = next_noise();
               step_q.push_back(make_out(pad_byte(cur_scheme, i, plen, filler), 1'b1));
            end
         end
      end else begin
         // unpad: a full held block is released when the next byte shows up
         if (item.byte_present) begin
            if (held_fill >= b) begin
               for (i = 0; i < b; i++) step_q.push_back(make_out(held_bytes[i], 1'b1));
               prior_block_seen  = 1'b1;
               prior_ended_zero  = (held_bytes[b-1] == PAD_ZERO);
               prior_ended_space = (held_bytes[b-1] == PAD_SPACE);
               held_fill = 0;
            end
            held_bytes[held_fill % STORE_DEPTH] = item.data_byte;
            held_fill++;
         end
         if (item.message_end) begin
            keep = (held_fill > b) ? b : held_fill;
            if (active && held_fill == b) keep = b - strip_length(b);
            for (i = 0; i < keep; i++) step_q.push_back(make_out(held_bytes[i], 1'b1));
         end
      end
      if (item.message_end) begin
         // an end always yields something: a bare marker if no bytes
         if (step_q.size() == 0) step_q.push_back(make_out(PAD_ZERO, 1'b0));
         last_out = step_q.pop_back();
         last_out.out_end = 1'b1;
         step_q.push_back(last_out);
         clear_message_state();
      end
      for (i = 0; i < step_q.size(); i++) out_stream_q.push_back(step_q[i]);
   endtask

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Called at a rising edge, returns at the edge where the transaction is taken
   task automatic send_transaction(logic [7:0] data, logic present, logic last);
      int unsigned pause;
      req_type     item;
      pause             = random_pause();
      item.data_byte    = data;
      item.byte_present = present;
      item.message_end  = last;
      if (pause != 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      pad_unpad_step(item);
      // ignored bare items don't count
      if (present || last) sent_items++;
   endtask

   // Every owed byte delivered, then let any silent work finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (out_stream_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      // direction and block size restart the message; seed reloads the LFSR
      case (idx)
         CSR_DIRECTION: begin
            cur_unpad = value[0];
            clear_message_state();
         end
         CSR_SCHEME:    cur_scheme = value[2:0];
         CSR_BLOCK: begin
            cur_block = value[5:0];
            clear_message_state();
         end
         CSR_MODE:      cur_mode_pads = value[0];
         CSR_SEED:      noise_reg = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_mode(logic unpad, logic [2:0] scheme_sel, logic [5:0] blk,
                           logic pads);
      write_reg(CSR_DIRECTION, unpad);
      write_reg(CSR_SCHEME, scheme_sel);
      write_reg(CSR_BLOCK, blk);
      write_reg(CSR_MODE, pads);
   endtask

   // ---------------------------------------------------------------------
   // Response side: random backpressure and in-order checking
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_stall
      int unsigned pause;
      if (reset || calm_mode) begin
         rsp_ready  <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         pause = random_pause();
         if (pause == 0) begin
            rsp_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 6);
         end else begin
            rsp_ready  <= 1'b0;
            ready_hold <= pause - 1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (out_stream_q.size() == 0) begin
            report_error($sformatf("unexpected rsp transaction: byte %02h present %b end %b",
                                   rsp_data.out_byte, rsp_data.out_present,
                                   rsp_data.out_end));
         end else begin
            want = out_stream_q.pop_front();
            if (rsp_data.out_byte !== want.out_byte)
               report_error($sformatf("out_byte %02h, predicted %02h",
                                      rsp_data.out_byte, want.out_byte));
            if (rsp_data.out_present !== want.out_present)
               report_error($sformatf("out_present %b, predicted %b",
                                      rsp_data.out_present, want.out_present));
            if (rsp_data.out_end !== want.out_end)
               report_error($sformatf("out_end %b, predicted %b",
                                      rsp_data.out_end, want.out_end));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Reset values: scheme none passes through; the 32-byte block and the reset
   // seed show up in a full ISO 10126 pad block.
   task automatic test_reset_defaults();
      send_transaction(8'hA5, 1'b1, 1'b1);
      write_reg(CSR_SCHEME, SCHEME_ISO10126);
      send_transaction(8'h00, 1'b0, 1'b1);
   endtask

   // Pad direction, one short message per scheme at B=3
   task automatic test_pad_schemes();
      set_mode(1'b0, SCHEME_NONE, 6'd3, 1'b1);
      send_transaction(8'hFF, 1'b1, 1'b1);
      write_reg(CSR_SCHEME, SCHEME_X923);
      send_transaction(8'h00, 1'b0, 1'b1);           // empty message: full pad block
      write_reg(CSR_SCHEME, SCHEME_PKCS7);
      send_transaction(8'h00, 1'b1, 1'b1);
      write_reg(CSR_SCHEME, SCHEME_ISO10126);
      send_transaction(8'h5A, 1'b0, 1'b1);
      write_reg(CSR_SCHEME, SCHEME_ISO7816);
      send_transaction(8'h33, 1'b0, 1'b0);           // bare non-end: ignored
      send_transaction(8'h80, 1'b1, 1'b0);
      send_transaction(8'h7F, 1'b1, 1'b1);
      write_reg(CSR_SCHEME, SCHEME_ZERO);
      send_transaction(8'hFF, 1'b0, 1'b1);
      write_reg(CSR_SCHEME, SCHEME_SPACE);
      send_transaction(8'h01, 1'b0, 1'b1);
      write_reg(CSR_SCHEME, SCHEME_UNKNOWN);
      send_transaction(8'h00, 1'b0, 1'b1);           // no pad: bare marker
      write_reg(CSR_SCHEME, SCHEME_PKCS7);
      write_reg(CSR_MODE, 1'b0);                     // non-padding chaining mode
      send_transaction(8'h00, 1'b0, 1'b1);
      write_reg(CSR_MODE, 1'b1);
      // Direction write mid-message drops the count: full block follows
      send_transaction(8'h41, 1'b1, 1'b0);
      write_reg(CSR_DIRECTION, 1'b0);
      send_transaction(8'h00, 1'b0, 1'b1);
   endtask

   // Block size clamping and the stuck-at-zero seed
   task automatic test_block_extremes();
      set_mode(1'b0, SCHEME_PKCS7, 6'd0, 1'b1);
      send_transaction(8'h00, 1'b0, 1'b1);           // acts as B=1
      write_reg(CSR_SEED, 16'h0000);
      set_mode(1'b0, SCHEME_ISO10126, 6'd63, 1'b1);  // acts as B=32
      send_transaction(8'h00, 1'b0, 1'b1);
   endtask

   // Unpad direction at B=2: good pads, bad pads and pass-through cases
   task automatic test_unpad_checks();
      set_mode(1'b1, SCHEME_X923, 6'd2, 1'b1);
      send_transaction(8'h00, 1'b1, 1'b0);
      send_transaction(8'h02, 1'b1, 1'b1);           // all pad: bare marker
      write_reg(CSR_SCHEME, SCHEME_PKCS7);
      send_transaction(8'h01, 1'b1, 1'b0);
      send_transaction(8'h03, 1'b1, 1'b1);           // pad length above B
      write_reg(CSR_SCHEME, SCHEME_ISO10126);
      send_transaction(8'h7F, 1'b1, 1'b0);
      send_transaction(8'h01, 1'b1, 1'b1);
      write_reg(CSR_SCHEME, SCHEME_ISO7816);
      send_transaction(8'h00, 1'b1, 1'b0);
      send_transaction(8'h00, 1'b1, 1'b1);           // no 0x80 marker
      write_reg(CSR_SCHEME, SCHEME_ZERO);
      send_transaction(8'h00, 1'b1, 1'b0);
      send_transaction(8'h00, 1'b1, 1'b0);
      send_transaction(8'h00, 1'b1, 1'b0);
      send_transaction(8'h00, 1'b1, 1'b1);           // earlier block ended in zero
      write_reg(CSR_SCHEME, SCHEME_SPACE);
      send_transaction(8'h41, 1'b1, 1'b0);
      send_transaction(8'h20, 1'b1, 1'b1);
      write_reg(CSR_SCHEME, SCHEME_PKCS7);
      send_transaction(8'h11, 1'b1, 1'b1);           // unaligned: passes through
      // Block size write drops the held byte
      send_transaction(8'h12, 1'b1, 1'b0);
      write_reg(CSR_BLOCK, 6'd2);
      send_transaction(8'hC3, 1'b0, 1'b1);
   endtask

   // Biased toward pad-like values so the checks see near misses
   function automatic logic [7:0] pick_byte(int unsigned b);
      logic [7:0] value;
      case ($urandom_range(0, 9))
         0:       value = PAD_ZERO;
         1:       value = PAD_SPACE;
         2:       value = PAD_ISO_MARK;
         3:       value = $urandom_range(1, b);
         default: value = $urandom_range(0, 255);
      endcase
      return value;
   endfunction

   // One message; in unpad mode mostly properly padded, some corrupted
   task automatic send_random_message();
      logic [7:0]  body [$];
      logic [7:0]  flip;
      int unsigned b, len, plen, i, pick;
      logic        bare_end;
      b   = active_block_bytes();
      len = $urandom_range(0, (b > 8) ? b + 3 : 2 * b + 2);
      for (i = 0; i < len; i++) body.push_back(pick_byte(b));
      if (cur_unpad && $urandom_range(0, 3) != 0) begin
         plen = b - (len % b);
         for (i = 0; i < plen; i++) body.push_back(pad_byte(cur_scheme, i, plen, pick_byte(b)));
      end
      if (cur_unpad && body.size() != 0 && $urandom_range(0, 4) == 0) begin
         pick = $urandom_range(0, body.size() - 1);
         case ($urandom_range(0, 2))
            0: begin
               flip = $urandom_range(1, 255);
               body[pick] = body[pick] ^ flip;
            end
            1:       flip = body.pop_back();
            default: body.push_back(pick_byte(b));
         endcase
      end
      bare_end = (body.size() == 0) || ($urandom_range(0, 3) == 0);
      for (i = 0; i < body.size(); i++) begin
         if ($urandom_range(0, 19) == 0) send_transaction(pick_byte(b), 1'b0, 1'b0);
         send_transaction(body[i], 1'b1, !bare_end && (i + 1 == body.size()));
      end
      if (bare_end) send_transaction(pick_byte(b), 1'b0, 1'b1);
   endtask

   // Random settings per phase, a few messages each; small blocks dominate
   task automatic test_random_traffic();
      int unsigned first_item, msgs, m, roll;
      logic [5:0]  blk;
      logic [2:0]  scheme_sel;
      logic [15:0] seed;
      first_item = sent_items;
      while (sent_items - first_item < RANDOM_ITEMS) begin
         calm_mode <= ($urandom_range(0, 4) == 0);
         roll = $urandom_range(0, 39);
         if (roll < 28)       blk = $urandom_range(1, 8);
         else if (roll < 33)  blk = $urandom_range(9, 16);
         else if (roll == 33) blk = 6'd0;
         else if (roll == 34) blk = $urandom_range(33, 63);
         else if (roll == 35) blk = 6'd32;
         else                 blk = $urandom_range(17, 31);
         if ($urandom_range(0, 9) != 0) scheme_sel = $urandom_range(1, 6);
         else scheme_sel = $urandom_range(0, 1) ? SCHEME_NONE : SCHEME_UNKNOWN;
         set_mode($urandom_range(0, 1), scheme_sel, blk, $urandom_range(0, 9) != 0);
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 4))
               0:       seed = 16'h0000;
               1:       seed = 16'hFFFF;
               default: seed = $urandom_range(1, 65535);
            endcase
            write_reg(CSR_SEED, seed);
         end
         msgs = (active_block_bytes() > 8) ? 1 : $urandom_range(1, 3);
         for (m = 0; m < msgs; m++) send_random_message();
      end
      calm_mode <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin : run_tests
      int unsigned drain_wait;
      // Mirror starts at the block's reset state
      cur_unpad     = 1'b0;
      cur_scheme    = SCHEME_NONE;
      cur_block     = BLOCK_RESET;
      cur_mode_pads = 1'b1;
      noise_reg     = SEED_RESET;
      clear_message_state();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_pad_schemes();
      test_block_extremes();
      test_unpad_checks();
      test_random_traffic();

      // Drain, bounded, then a quiet stretch for any stray response
      req_valid <= 1'b0;
      for (drain_wait = 0; out_stream_q.size() != 0 && drain_wait < DRAIN_LIMIT;
           drain_wait++)
         @(posedge clock);
      if (out_stream_q.size() != 0)
         report_error($sformatf("%0d predicted rsp transactions never arrived",
                                out_stream_q.size()));
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Hang guard
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: sim.f
sv/blkpad_pkg.sv
sv/blkpad_ram.sv
sv/blkpad_noise.sv
sv/blkpad_check.sv
sv/block_cipher_pad_unpad.sv
tb/sv/tb_block_cipher_pad_unpad.sv
